### src/arp_cache_table_unit_macros.svh
// Assertion macros shared by the ARP cache table unit.
`ifndef ARP_CACHE_TABLE_UNIT_MACROS_SVH
`define ARP_CACHE_TABLE_UNIT_MACROS_SVH

// Checks that cond implies expr in the same cycle.
`define ACT_ASSERT_IMPL(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Checks that cond implies expr in the following cycle.
`define ACT_ASSERT_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

### src/act_pkg.sv
// Types and constants shared by the ARP cache table unit modules.
package act_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ALLOC  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [2:0] KIND_ALLOCATED = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_HIT       = 3'd2;
  localparam logic [2:0] KIND_MISS      = 3'd3;
  localparam logic [2:0] KIND_RETRY     = 3'd4;
  localparam logic [2:0] KIND_DROPPED   = 3'd5;
  localparam logic [2:0] KIND_TICK_DONE = 3'd6;

  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_WAIT     = 2'd1;
  localparam logic [1:0] ST_RESOLVED = 2'd2;

  localparam logic [1:0] CFG_RESOLVED_LIFETIME = 2'd0;
  localparam logic [1:0] CFG_WAIT_TIME         = 2'd1;
  localparam logic [1:0] CFG_REQUEST_RETRIES   = 2'd2;

  localparam logic [15:0] IPV4_PROTO = 16'h0800;

  // Retry and drop results reported per tick.
  localparam int EV_W = 5;
  localparam logic [EV_W-1:0] MAX_EVENTS = 5'd16;

  typedef struct packed {
    logic [15:0] protocol;
    logic [31:0] ip;
    logic [47:0] hw;
    logic [17:0] lifetime;
    logic [4:0]  retries;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic alloc;
    logic hit;
    logic age;
    logic report;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic match;
    logic expire_event;
    logic space;
  } sts_t;

endpackage

### src/act_ctrl.sv
// Controller state machine that sequences the slot scans of the ARP cache table.
module act_ctrl #(
  parameter int ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [1:0]          operation,
  output logic                req_stall,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] alloc_ptr,
  input  act_pkg::sts_t       sts,
  output act_pkg::cmd_t       cmd,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] idx,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_idx
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0]                  state, state_next;
  logic [IDX_W-1:0]            idx_next, cnt, cnt_next, idx_inc;
  logic [act_pkg::EV_W-1:0]    events, events_next;
  logic                        last_step;
  logic                        report;

  assign req_stall = (state != S_IDLE);
  assign idx_inc   = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign last_step = (cnt == LAST_IDX);
  assign report    = (events != act_pkg::MAX_EVENTS);

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    cnt_next    = cnt;
    events_next = events;
    rd_idx      = idx;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        // Slot 0 is read ahead so a lookup or tick can evaluate it at once.
        rd_idx = '0;
        if (req_valid) begin
          cmd.accept  = 1'b1;
          cnt_next    = '0;
          events_next = '0;
          case (operation)
            act_pkg::OP_INSERT, act_pkg::OP_ALLOC: begin
              idx_next   = alloc_ptr;
              state_next = S_ALLOC;
            end
            act_pkg::OP_LOOKUP: begin
              idx_next   = '0;
              state_next = S_LOOK;
            end
            default: begin
              idx_next   = '0;
              state_next = S_TICK;
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (sts.slot_free) begin
          if (sts.space) begin
            cmd.alloc  = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          idx_next = idx_inc;
          cnt_next = cnt + 1'b1;
          if (last_step) begin
            state_next = S_FINAL;
          end
        end
      end
      S_LOOK: begin
        if (sts.match) begin
          if (sts.space) begin
            cmd.hit    = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          rd_idx   = idx_inc;
          idx_next = idx_inc;
          cnt_next = cnt + 1'b1;
          if (last_step) begin
            state_next = S_FINAL;
          end
        end
      end
      S_TICK: begin
        cmd.report = report;
        // A slot that must report waits until the output register can take it.
        if (!(sts.expire_event && report) || sts.space) begin
          cmd.age  = 1'b1;
          rd_idx   = idx_inc;
          idx_next = idx_inc;
          cnt_next = cnt + 1'b1;
          if (sts.expire_event && report) begin
            events_next = events + 1'b1;
          end
          if (last_step) begin
            state_next = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        if (sts.space) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      idx    <= '0;
      cnt    <= '0;
      events <= '0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      cnt    <= cnt_next;
      events <= events_next;
    end
  end

endmodule

### src/act_datapath.sv
// Datapath of the ARP cache table: slot store, configuration, request and result registers.
module act_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  act_pkg::cmd_t cmd,
  output act_pkg::sts_t sts,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] idx,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_idx,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] alloc_ptr,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic [1:0]    operation,
  input  logic [15:0]   protocol,
  input  logic [31:0]   ip_address,
  input  logic [47:0]   hw_address,
  input  logic [15:0]   elapsed,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output logic [2:0]    kind,
  output logic [3:0]    entry_index,
  output logic [1:0]    entry_status,
  output logic [15:0]   found_protocol,
  output logic [31:0]   found_ip,
  output logic [47:0]   found_hw,
  output logic          last
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [15:0] resolved_lifetime;
  logic [15:0] wait_time;
  logic [3:0]  request_retries;

  logic [1:0]  req_op;
  logic [15:0] req_protocol;
  logic [31:0] req_ip;
  logic [47:0] req_hw;
  logic [15:0] req_elapsed;

  act_pkg::entry_t slot_mem [ENTRIES];
  act_pkg::entry_t rd_data, wr_data, alloc_entry, age_entry;
  logic [1:0]      slot_status [ENTRIES];

  logic [1:0]        cur_status, alloc_status;
  logic              used, waiting, expired, drop, insert;
  logic signed [17:0] life_new;
  logic [4:0]        retry_new;
  logic              mem_we, free_now, emit_event, load;
  logic [IDX_W-1:0]  idx_inc;

  logic [2:0]  kind_next;
  logic [3:0]  index_next;
  logic [1:0]  status_next;
  logic [15:0] protocol_next;
  logic [31:0] ip_next;
  logic [47:0] hw_next;
  logic        last_next;

  assign cur_status = slot_status[idx];
  assign used       = (cur_status != act_pkg::ST_FREE);
  assign waiting    = (cur_status == act_pkg::ST_WAIT);
  assign insert     = (req_op == act_pkg::OP_INSERT);
  assign idx_inc    = (idx == LAST_IDX) ? '0 : idx + 1'b1;

  assign life_new  = $signed(rd_data.lifetime) - $signed({2'b00, req_elapsed});
  assign expired   = life_new[17] || (life_new == '0);
  assign retry_new = rd_data.retries - 5'd1;
  assign drop      = retry_new[4];

  always_comb begin
    sts.slot_free    = !used;
    sts.match        = used && (rd_data.protocol == req_protocol) && (rd_data.ip == req_ip);
    sts.expire_event = used && expired && waiting;
    sts.space        = !rsp_valid || !rsp_stall;
  end

  always_comb begin
    alloc_entry.protocol = insert ? req_protocol : act_pkg::IPV4_PROTO;
    alloc_entry.ip       = req_ip;
    alloc_entry.hw       = insert ? req_hw : '0;
    alloc_entry.lifetime = {2'b00, (insert ? resolved_lifetime : wait_time)};
    alloc_entry.retries  = {1'b0, request_retries};
    alloc_status         = insert ? act_pkg::ST_RESOLVED : act_pkg::ST_WAIT;

    age_entry = rd_data;
    if (expired) begin
      age_entry.lifetime = {2'b00, wait_time};
      age_entry.retries  = retry_new;
    end else begin
      age_entry.lifetime = life_new;
    end
  end

  // A used slot is rewritten unless it expires into the free state.
  assign mem_we     = cmd.alloc || (cmd.age && used && (!expired || (waiting && !drop)));
  assign wr_data    = cmd.alloc ? alloc_entry : age_entry;
  assign free_now   = cmd.age && used && expired && (!waiting || drop);
  assign emit_event = cmd.age && sts.expire_event && cmd.report;
  assign load       = cmd.alloc || cmd.hit || emit_event || cmd.fin;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[idx] <= wr_data;
    end
    rd_data <= slot_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_status <= '{default: act_pkg::ST_FREE};
      alloc_ptr   <= '0;
    end else begin
      if (cmd.alloc) begin
        slot_status[idx] <= alloc_status;
        alloc_ptr        <= idx_inc;
      end else if (free_now) begin
        slot_status[idx] <= act_pkg::ST_FREE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resolved_lifetime <= 16'd600;
      wait_time         <= 16'd1;
      request_retries   <= 4'd4;
    end else if (cfg_write) begin
      case (cfg_index)
        act_pkg::CFG_RESOLVED_LIFETIME: resolved_lifetime <= cfg_data;
        act_pkg::CFG_WAIT_TIME:         wait_time <= cfg_data;
        act_pkg::CFG_REQUEST_RETRIES:   request_retries <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op       <= operation;
      req_protocol <= protocol;
      req_ip       <= ip_address;
      req_hw       <= hw_address;
      req_elapsed  <= elapsed;
    end
  end

  always_comb begin
    kind_next     = act_pkg::KIND_TICK_DONE;
    index_next    = '0;
    status_next   = act_pkg::ST_FREE;
    protocol_next = '0;
    ip_next       = '0;
    hw_next       = '0;
    last_next     = 1'b1;
    if (cmd.alloc) begin
      kind_next     = act_pkg::KIND_ALLOCATED;
      index_next    = 4'(idx);
      status_next   = alloc_status;
      protocol_next = alloc_entry.protocol;
      ip_next       = alloc_entry.ip;
      hw_next       = alloc_entry.hw;
    end else if (cmd.hit) begin
      kind_next     = act_pkg::KIND_HIT;
      index_next    = 4'(idx);
      status_next   = cur_status;
      protocol_next = rd_data.protocol;
      ip_next       = rd_data.ip;
      hw_next       = rd_data.hw;
    end else if (emit_event) begin
      kind_next     = drop ? act_pkg::KIND_DROPPED : act_pkg::KIND_RETRY;
      index_next    = 4'(idx);
      status_next   = drop ? act_pkg::ST_FREE : act_pkg::ST_WAIT;
      protocol_next = rd_data.protocol;
      ip_next       = rd_data.ip;
      hw_next       = rd_data.hw;
      last_next     = 1'b0;
    end else begin
      case (req_op)
        act_pkg::OP_LOOKUP: kind_next = act_pkg::KIND_MISS;
        act_pkg::OP_TICK:   kind_next = act_pkg::KIND_TICK_DONE;
        default:            kind_next = act_pkg::KIND_FULL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind           <= kind_next;
      entry_index    <= index_next;
      entry_status   <= status_next;
      found_protocol <= protocol_next;
      found_ip       <= ip_next;
      found_hw       <= hw_next;
      last           <= last_next;
    end
  end

endmodule

### src/arp_cache_table_unit.sv
// ARP cache table unit: top level joining the controller and the datapath.
//
// Requests enter on the req channel (req_valid / req_stall): an insert, an
// allocation, a lookup or a time tick. Results leave on the rsp channel
// (rsp_valid / rsp_stall), each with last set on the final result of a request.
// Configuration registers are written on the cfg channel (cfg_valid /
// cfg_ready, index and data); cfg_ready is always high.
// One request is worked on at a time; req_stall is high from the cycle after
// acceptance until its final result is loaded into the output register.
// Each request scans the slots one per cycle, unless a stalled receiver holds
// the scan, through a slot store with one read and one write port: an
// allocation starts at the rotating pointer, a lookup and a tick at slot 0.
// A tick visits every slot; an allocation or a lookup stops at the first free
// or matching slot.
// The result register frees up in the cycle it is taken, so a new request is
// accepted while the last result still waits. A stalled receiver holds the
// scan only when another result must be produced.
// Reset clears every slot to free, the pointer to zero and loads the default
// configuration; all slot states clear together, with no clearing pass.
module arp_cache_table_unit #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] protocol,
  input  logic [31:0] ip_address,
  input  logic [47:0] hw_address,
  input  logic [15:0] elapsed,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  kind,
  output logic [3:0]  entry_index,
  output logic [1:0]  entry_status,
  output logic [15:0] found_protocol,
  output logic [31:0] found_ip,
  output logic [47:0] found_hw,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

`include "arp_cache_table_unit_macros.svh"

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  act_pkg::cmd_t    cmd;
  act_pkg::sts_t    sts;
  logic [IDX_W-1:0] idx, rd_idx, alloc_ptr;
  logic             rsp_load, req_done;

  assign cfg_ready = 1'b1;

  assign req_done = cmd.alloc || cmd.hit || cmd.fin;
  assign rsp_load = req_done || (cmd.age && sts.expire_event && cmd.report);

  act_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .operation (operation),
    .req_stall (req_stall),
    .alloc_ptr (alloc_ptr),
    .sts       (sts),
    .cmd       (cmd),
    .idx       (idx),
    .rd_idx    (rd_idx)
  );

  act_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .idx            (idx),
    .rd_idx         (rd_idx),
    .alloc_ptr      (alloc_ptr),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .protocol       (protocol),
    .ip_address     (ip_address),
    .hw_address     (hw_address),
    .elapsed        (elapsed),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .kind           (kind),
    .entry_index    (entry_index),
    .entry_status   (entry_status),
    .found_protocol (found_protocol),
    .found_ip       (found_ip),
    .found_hw       (found_hw),
    .last           (last)
  );

  // A result may only be produced when the output register has room for it.
  `ACT_ASSERT_IMPL(a_result_has_room, rsp_load, !rsp_valid || !rsp_stall, "output register busy")
  `ACT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "no stall after accept")
  `ACT_ASSERT_NEXT(a_idle_after_final, req_done, !req_stall && rsp_valid && last, "no final result")

endmodule

### bench/testbench.sv
// Self-checking testbench for the ARP cache table unit, with its own table predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int ENTRIES = 16;
  // Cycles with no handshake on any channel before the run is called hung.
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [1:0]  status;
    logic [15:0] proto;
    logic [31:0] ip;
    logic [47:0] hw;
    logic        last;
  } reply_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  operation = act_pkg::OP_LOOKUP;
  logic [15:0] protocol = '0;
  logic [31:0] ip_address = '0;
  logic [47:0] hw_address = '0;
  logic [15:0] elapsed = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [2:0]  kind;
  logic [3:0]  entry_index;
  logic [1:0]  entry_status;
  logic [15:0] found_protocol;
  logic [31:0] found_ip;
  logic [47:0] found_hw;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = act_pkg::CFG_RESOLVED_LIFETIME;
  logic [15:0] cfg_data = '0;

  // Table as the block should hold it.
  logic [1:0]  tbl_state [ENTRIES];
  logic [15:0] tbl_proto [ENTRIES];
  logic [31:0] tbl_ip [ENTRIES];
  logic [47:0] tbl_hw [ENTRIES];
  int          tbl_life [ENTRIES];
  int          tbl_tries [ENTRIES];
  int          alloc_ptr;
  logic [15:0] cfg_lifetime;
  logic [15:0] cfg_wait;
  logic [3:0]  cfg_retries;

  reply_t pending_replies[$];
  int     mismatches = 0;
  int     quiet_cycles = 0;
  int     stall_run = 0;
  bit     calm = 1'b0;

  arp_cache_table_unit #(.ENTRIES(ENTRIES)) uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .protocol(protocol), .ip_address(ip_address),
    .hw_address(hw_address), .elapsed(elapsed),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .kind(kind), .entry_index(entry_index), .entry_status(entry_status),
    .found_protocol(found_protocol), .found_ip(found_ip), .found_hw(found_hw),
    .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic reply_t slot_reply(input logic [2:0] k, input int s, input logic fin);
    reply_t r;
    r.kind = k;
    r.slot = s[3:0];
    r.status = tbl_state[s];
    r.proto = tbl_proto[s];
    r.ip = tbl_ip[s];
    r.hw = tbl_hw[s];
    r.last = fin;
    return r;
  endfunction

  function automatic reply_t empty_reply(input logic [2:0] k);
    reply_t r;
    r = '0;
    r.kind = k;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_state[i] = act_pkg::ST_FREE;
      tbl_proto[i] = '0;
      tbl_ip[i] = '0;
      tbl_hw[i] = '0;
      tbl_life[i] = 0;
      tbl_tries[i] = 0;
    end
    alloc_ptr = 0;
    cfg_lifetime = 16'd600;
    cfg_wait = 16'd1;
    cfg_retries = 4'd4;
  endfunction

  // Updates the table for one accepted request and queues the replies it must produce.
  function automatic void resolve_request(input logic [1:0] op, input logic [15:0] proto,
                                          input logic [31:0] ip, input logic [47:0] hw,
                                          input logic [15:0] el);
    int s;
    int p;
    int n;
    int i;
    s = -1;
    case (op)
      act_pkg::OP_INSERT, act_pkg::OP_ALLOC: begin
        p = alloc_ptr;
        for (i = 0; i < ENTRIES; i++) begin
          if (s < 0 && tbl_state[p] == act_pkg::ST_FREE) s = p;
          p = (p + 1) % ENTRIES;
        end
        if (s < 0) begin
          pending_replies.push_back(empty_reply(act_pkg::KIND_FULL));
        end else begin
          tbl_tries[s] = int'(cfg_retries);
          tbl_ip[s] = ip;
          if (op == act_pkg::OP_INSERT) begin
            tbl_state[s] = act_pkg::ST_RESOLVED;
            tbl_proto[s] = proto;
            tbl_hw[s] = hw;
            tbl_life[s] = int'(cfg_lifetime);
          end else begin
            tbl_state[s] = act_pkg::ST_WAIT;
            tbl_proto[s] = act_pkg::IPV4_PROTO;
            tbl_hw[s] = '0;
            tbl_life[s] = int'(cfg_wait);
          end
          alloc_ptr = (s + 1) % ENTRIES;
          pending_replies.push_back(slot_reply(act_pkg::KIND_ALLOCATED, s, 1'b1));
        end
      end
      act_pkg::OP_LOOKUP: begin
        for (i = 0; i < ENTRIES; i++) begin
          if (s < 0 && tbl_state[i] != act_pkg::ST_FREE && tbl_proto[i] == proto &&
              tbl_ip[i] == ip)
            s = i;
        end
        if (s < 0) pending_replies.push_back(empty_reply(act_pkg::KIND_MISS));
        else pending_replies.push_back(slot_reply(act_pkg::KIND_HIT, s, 1'b1));
      end
      default: begin
        n = 0;
        for (i = 0; i < ENTRIES; i++) begin
          if (tbl_state[i] != act_pkg::ST_FREE) begin
            tbl_life[i] -= int'(el);
            if (tbl_life[i] <= 0) begin
              if (tbl_state[i] == act_pkg::ST_RESOLVED) begin
                tbl_state[i] = act_pkg::ST_FREE;
              end else begin
                tbl_tries[i] -= 1;
                // Events past the per-tick cap still change the slot, silently.
                if (tbl_tries[i] < 0) begin
                  tbl_state[i] = act_pkg::ST_FREE;
                  if (n < int'(act_pkg::MAX_EVENTS))
                    pending_replies.push_back(slot_reply(act_pkg::KIND_DROPPED, i, 1'b0));
                end else begin
                  tbl_life[i] = int'(cfg_wait);
                  if (n < int'(act_pkg::MAX_EVENTS))
                    pending_replies.push_back(slot_reply(act_pkg::KIND_RETRY, i, 1'b0));
                end
                if (n < int'(act_pkg::MAX_EVENTS)) n++;
              end
            end
          end
        end
        pending_replies.push_back(empty_reply(act_pkg::KIND_TICK_DONE));
      end
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the request is accepted.
  task automatic send_request(input logic [1:0] op, input logic [15:0] proto,
                              input logic [31:0] ip, input logic [47:0] hw,
                              input logic [15:0] el);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    protocol <= proto;
    ip_address <= ip;
    hw_address <= hw;
    elapsed <= el;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    resolve_request(op, proto, ip, hw, el);
  endtask

  task automatic wait_replies();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic set_config(input logic [15:0] life, input logic [15:0] wt,
                            input logic [3:0] tries);
    logic [1:0]  regs [3];
    logic [15:0] values [3];
    regs = '{act_pkg::CFG_RESOLVED_LIFETIME, act_pkg::CFG_WAIT_TIME,
             act_pkg::CFG_REQUEST_RETRIES};
    values = '{life, wt, {12'd0, tries}};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= values[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cfg_lifetime = life;
    cfg_wait = wt;
    cfg_retries = tries;
  endtask

  task automatic test_lookup_and_insert();
    send_request(act_pkg::OP_LOOKUP, 16'h0000, 32'h0000_0000, 48'h0, 16'h0000);
    send_request(act_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    send_request(act_pkg::OP_INSERT, 16'h0000, 32'h0000_0000, 48'h0000_0000_0000, 16'h0000);
    // Same key again: a second slot is taken, and lookups still find the first.
    send_request(act_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 48'h0123_4567_89AB, 16'h0000);
    send_request(act_pkg::OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 48'h0, 16'h0000);
    send_request(act_pkg::OP_LOOKUP, 16'h0000, 32'h0000_0000, 48'h0, 16'h0000);
  endtask

  task automatic test_allocate();
    send_request(act_pkg::OP_ALLOC, 16'h1234, 32'h0A00_0001, 48'hDEAD_BEEF_0001, 16'h0000);
    send_request(act_pkg::OP_LOOKUP, act_pkg::IPV4_PROTO, 32'h0A00_0001, 48'h0, 16'h0000);
    // The protocol of an allocate request is not stored.
    send_request(act_pkg::OP_LOOKUP, 16'h1234, 32'h0A00_0001, 48'h0, 16'h0000);
    send_request(act_pkg::OP_TICK, 16'h0000, 32'h0, 48'h0, 16'h0000);
  endtask

  task automatic test_table_full();
    wait_replies();
    set_config(16'd600, 16'd1, 4'd0);
    repeat (12) send_request(act_pkg::OP_ALLOC, 16'($urandom), $urandom,
                             48'({$urandom, $urandom}), 16'($urandom));
    send_request(act_pkg::OP_INSERT, 16'h0806, 32'hC0A8_0001, 48'h0200_0000_0001, 16'h0000);
  endtask

  task automatic test_tick_events();
    // Frees the resolved slots, rearms the first waiting slot, drops the rest.
    send_request(act_pkg::OP_TICK, 16'h0000, 32'h0, 48'h0, 16'hFFFF);
    send_request(act_pkg::OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 48'h0, 16'h0000);
  endtask

  task automatic test_random_traffic();
    logic [15:0] key_proto [8];
    logic [31:0] key_ip [8];
    logic [15:0] life;
    logic [15:0] wt;
    logic [3:0]  tries;
    logic [1:0]  op;
    logic [15:0] proto;
    logic [31:0] ip;
    logic [15:0] el;
    int          k;
    int          r;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin life = 16'hFFFF; wt = 16'hFFFF; tries = 4'hF; end
        1: begin life = 16'd1; wt = 16'd1; tries = 4'd0; end
        2: begin life = 16'd600; wt = 16'd1; tries = 4'd4; end
        default: begin
          life = 16'($urandom_range(1, 300));
          wt = 16'($urandom_range(1, 40));
          tries = 4'($urandom_range(0, 15));
        end
      endcase
      wait_replies();
      set_config(life, wt, tries);
      calm = (phase == 2);
      for (int i = 0; i < 8; i++) begin
        key_proto[i] = ($urandom_range(0, 1) == 0) ? act_pkg::IPV4_PROTO : 16'($urandom);
        key_ip[i] = $urandom;
      end
      for (int item = 0; item < 70; item++) begin
        // Hold back new requests until the table has answered everything.
        if (phase == 4 && item == 35) wait_replies();
        k = $urandom_range(0, 7);
        r = $urandom_range(0, 99);
        proto = ($urandom_range(0, 99) < 75) ? key_proto[k] : 16'($urandom);
        ip = ($urandom_range(0, 99) < 75) ? key_ip[k] : $urandom;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: el = 16'($urandom_range(0, 8));
          6, 7: el = 16'($urandom);
          8: el = 16'h0000;
          default: el = 16'hFFFF;
        endcase
        if (r < 28) op = act_pkg::OP_INSERT;
        else if (r < 52) op = act_pkg::OP_ALLOC;
        else if (r < 82) op = act_pkg::OP_LOOKUP;
        else op = act_pkg::OP_TICK;
        send_request(op, proto, ip, 48'({$urandom, $urandom}), el);
      end
    end
    calm = 1'b0;
  endtask

  // Receiver side: random stalls, with stall_run capping the length of a run.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_run <= 0;
    end else if (!calm && stall_run < 8 && $urandom_range(0, 99) < 30) begin
      rsp_stall <= 1'b1;
      stall_run <= stall_run + 1;
    end else begin
      rsp_stall <= 1'b0;
      stall_run <= 0;
    end
  end

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      got = {kind, entry_index, entry_status, found_protocol, found_ip, found_hw, last};
      if (pending_replies.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected reply: kind %0d slot %0d status %0d last %0b",
                   kind, entry_index, entry_status, last);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("reply mismatch at %0t", $realtime);
            $display("  expected kind %0d slot %0d status %0d proto %h ip %h hw %h last %0b",
                     want.kind, want.slot, want.status, want.proto, want.ip, want.hw,
                     want.last);
            $display("  actual   kind %0d slot %0d status %0d proto %h ip %h hw %h last %0b",
                     got.kind, got.slot, got.status, got.proto, got.ip, got.hw, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_table();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_lookup_and_insert();
    test_allocate();
    test_table_full();
    test_tick_events();
    test_random_traffic();
    wait_replies();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### arp_cache_table_unit.f
+incdir+src
src/act_pkg.sv
src/act_ctrl.sv
src/act_datapath.sv
src/arp_cache_table_unit.sv
bench/testbench.sv
